/* hdl/efn_pkg.sv */
// Shared constants, coefficients and types for the EEG filter and normalizer.
`timescale 1ns / 1ps
`default_nettype none
package efn_pkg;

    localparam int WINDOW_DEPTH = 256;

    // Widths of the shared serial units
    localparam int MUL_W   = 36;
    localparam int DIV_NW  = 64;
    localparam int DIV_DW  = 34;
    localparam int SQRT_W  = 32;
    localparam int CFG_IDX_W = 2;

    // Filter coefficients, Q2.28 magnitudes; signs live in the term table
    localparam logic [MUL_W-1:0] NT_B0 = 36'd260248175;
    localparam logic [MUL_W-1:0] NT_B1 = 36'd510591081;
    localparam logic [MUL_W-1:0] NT_A2 = 36'd252087737;
    localparam logic [MUL_W-1:0] HP_B  = 36'd257805412;
    localparam logic [MUL_W-1:0] HP_A  = 36'd247175368;
    localparam logic [MUL_W-1:0] LP_B  = 36'd12562779;
    localparam logic [MUL_W-1:0] LP_A  = 36'd243309897;

    localparam int FRAC = 28;
    localparam logic signed [65:0] ROUND_HALF = 66'sd134217728;

    localparam logic [62:0] SPREAD_MAX = 63'h4000_0000_0000_0000;
    localparam logic [47:0] VAR_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam logic [16:0] RES_ONE    = 17'd65536;

    localparam logic [30:0] INPUT_LIMIT_RST = 31'd65536000;
    localparam logic [30:0] MIN_SPAN_RST    = 31'd6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_LIMIT = 2'd0,
        CFG_MIN_SPAN    = 2'd1
    } cfg_idx_t;

endpackage
`default_nettype wire

/* hdl/efn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module efn_ram #(
    parameter int W     = 32,
    parameter int DEPTH = efn_pkg::WINDOW_DEPTH
) (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  wire logic [W-1:0]                  wr_data,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic      [W-1:0]                  rd_data
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

/* hdl/efn_mul.sv */
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module efn_mul #(
    parameter int W = efn_pkg::MUL_W
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [W-1:0]   a,
    input  wire logic [W-1:0]   b,
    output logic                done,
    output logic [2*W-1:0]      p
);
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     a_reg, b_reg;
    logic [2*W-1:0]   p_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [W:0]       sum;

    assign sum  = {1'b0, p_reg[2*W-1:W]} + {1'b0, (b_reg[0] ? a_reg : {W{1'b0}})};
    assign done = done_reg;
    assign p    = p_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= a;
                b_reg    <= b;
                p_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                p_reg   <= {sum, p_reg[W-1:1]};
                b_reg   <= b_reg >> 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/efn_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module efn_div #(
    parameter int NW = efn_pkg::DIV_NW,
    parameter int DW = efn_pkg::DIV_DW
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [NW-1:0] n,
    input  wire logic [DW-1:0] d,
    output logic               done,
    output logic [NW-1:0]      q
);
    localparam int CNT_W = $clog2(NW);

    logic [NW-1:0]    q_reg;
    logic [DW-1:0]    r_reg, d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DW:0]      trial, r_next;
    logic             ge;

    assign trial  = {r_reg, q_reg[NW-1]};
    assign ge     = trial >= {1'b0, d_reg};
    assign r_next = ge ? trial - {1'b0, d_reg} : trial;
    assign done   = done_reg;
    assign q      = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                q_reg    <= n;
                d_reg    <= d;
                r_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                r_reg   <= r_next[DW-1:0];
                q_reg   <= {q_reg[NW-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/efn_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module efn_sqrt #(
    parameter int RW = efn_pkg::SQRT_W
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [2*RW-1:0] n,
    output logic                 done,
    output logic [RW-1:0]        root
);
    localparam int CNT_W = $clog2(RW);

    logic [2*RW-1:0]  n_reg;
    logic [RW:0]      rem_reg;
    logic [RW-1:0]    root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [RW+1:0]    rem_sh, trial, rem_next;
    logic             ge;

    assign rem_sh   = {rem_reg[RW-1:0], n_reg[2*RW-1:2*RW-2]};
    assign trial    = {root_reg, 2'b01};
    assign ge       = rem_sh >= trial;
    assign rem_next = ge ? rem_sh - trial : rem_sh;
    assign done     = done_reg;
    assign root     = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                n_reg    <= n;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= rem_next[RW:0];
                root_reg <= {root_reg[RW-2:0], ge};
                n_reg    <= n_reg << 2;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(RW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/eeg_filter_normalize.sv */
// Top level: EEG sample filter cascade with sliding-window normalization.
// Flow: a rejected sample is answered straight from the range check; an accepted
//   one runs 11 filter taps on the serial multiplier, a window-mean divide, one more
//   multiply and, when the value lies strictly inside the span, a normalizing divide;
//   the bounds refresh every WINDOW_DEPTH accepted samples adds a divide and a root.
// Throughput: one sample at a time; the serial multiplier and divider set the rate.
// Reset (aresetn low, synchronous): filters and window statistics clear, bounds return
//   to 0 and 65536, registers return to defaults; window RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module eeg_filter_normalize #(
    parameter int WINDOW_DEPTH = efn_pkg::WINDOW_DEPTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // sample requests
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [31:0]            s_sample,
    // results
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [16:0]                        m_normalized,
    output logic                               m_rejected,
    // register writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [efn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);
    localparam int POS_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int MW    = efn_pkg::MUL_W;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_MUL_GO, ST_MUL_WAIT, ST_ROUND,
        ST_WIN_RD, ST_WIN_DELTA, ST_WIN_DIV, ST_WIN_D2, ST_WIN_MUL,
        ST_BND_GO, ST_BND_DIV, ST_BND_SQRT, ST_BND_SET,
        ST_NORM, ST_NORM_DIV, ST_OUT
    } state_t;

    // Filter taps in evaluation order: notch, high-pass, low-pass
    typedef enum logic [3:0] {
        T_NT_X, T_NT_IN0, T_NT_IN1, T_NT_OUT0, T_NT_OUT1,
        T_HP_X, T_HP_IN, T_HP_OUT,
        T_LP_X, T_LP_IN, T_LP_OUT
    } term_t;

    state_t state_reg;
    term_t  term_reg;

    logic signed [31:0] x_reg;
    logic signed [65:0] acc_reg;
    logic signed [31:0] nin0_reg, nin1_reg, nout0_reg, nout1_reg;
    logic signed [31:0] hpin_reg, hpout_reg, lpin_reg, lpout_reg;
    logic signed [31:0] mean_reg, nm_reg, old_reg, lower_reg, upper_reg;
    logic signed [32:0] da_reg;
    logic [62:0]        spread_reg;
    logic [CNT_W-1:0]   fill_reg, period_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [30:0]        input_limit_reg, min_span_reg;
    logic [33:0]        sd3_reg;
    logic               neg_reg;
    logic [16:0]        res_reg;
    logic               rej_reg;
    logic               m_valid_reg;
    logic [16:0]        m_norm_reg;
    logic               m_rej_reg;

    // Serial unit requests
    logic                       mul_start_reg, div_start_reg, sqrt_start_reg;
    logic [MW-1:0]              mul_a_reg, mul_b_reg;
    logic [efn_pkg::DIV_NW-1:0] div_n_reg;
    logic [efn_pkg::DIV_DW-1:0] div_d_reg;
    logic [2*efn_pkg::SQRT_W-1:0] sqrt_n_reg;
    logic                       mul_done, div_done, sqrt_done;
    logic [2*MW-1:0]            mul_p;
    logic [efn_pkg::DIV_NW-1:0] div_q;
    logic [efn_pkg::SQRT_W-1:0] sqrt_root;
    logic signed [31:0]         ram_rdata;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [MW-1:0] term_coef(input term_t t);
        unique case (t)
            T_NT_X, T_NT_IN1:    return efn_pkg::NT_B0;
            T_NT_IN0, T_NT_OUT0: return efn_pkg::NT_B1;
            T_NT_OUT1:           return efn_pkg::NT_A2;
            T_HP_X, T_HP_IN:     return efn_pkg::HP_B;
            T_HP_OUT:            return efn_pkg::HP_A;
            T_LP_X, T_LP_IN:     return efn_pkg::LP_B;
            T_LP_OUT:            return efn_pkg::LP_A;
            default:             return '0;
        endcase
    endfunction

    function automatic logic term_neg(input term_t t);
        return (t == T_NT_IN0) || (t == T_NT_OUT1) || (t == T_HP_IN);
    endfunction

    // Tap operand: history is updated at each stage end, so the newest
    // stage output already sits in its history register.
    logic signed [31:0] op;
    always_comb begin
        unique case (term_reg)
            T_NT_X:    op = x_reg;
            T_NT_IN0:  op = nin0_reg;
            T_NT_IN1:  op = nin1_reg;
            T_NT_OUT0: op = nout0_reg;
            T_NT_OUT1: op = nout1_reg;
            T_HP_X:    op = nout0_reg;
            T_HP_IN:   op = hpin_reg;
            T_HP_OUT:  op = hpout_reg;
            T_LP_X:    op = hpout_reg;
            T_LP_IN:   op = lpin_reg;
            T_LP_OUT:  op = lpout_reg;
            default:   op = '0;
        endcase
    end

    logic signed [32:0] op_ext, x_ext;
    logic [32:0]        op_mag, x_mag;
    logic signed [65:0] prod66, acc_rnd, acc_sh;
    logic signed [31:0] rnd_val;
    logic               full;
    logic signed [32:0] da, da_abs;
    logic signed [34:0] q35, qs, t1, t2, d2, d2_abs;
    logic signed [64:0] spread_upd;
    logic [62:0]        spread_clamped;
    logic [47:0]        var48;
    logic               narrow;
    logic signed [35:0] mean36, lo36, hi36;
    logic signed [32:0] num, span;
    logic               norm_div;

    always_comb begin
        op_ext  = 33'(op);
        op_mag  = op_ext[32] ? 33'(-op_ext) : 33'(op_ext);
        x_ext   = 33'(x_reg);
        x_mag   = x_ext[32] ? 33'(-x_ext) : 33'(x_ext);
        prod66  = signed'({6'b0, mul_p[59:0]});
        acc_rnd = acc_reg + efn_pkg::ROUND_HALF;
        acc_sh  = acc_rnd >>> efn_pkg::FRAC;
        rnd_val = sat32(acc_sh);

        full    = (fill_reg == CNT_W'(WINDOW_DEPTH));
        da      = full ? 33'(lpout_reg) - 33'(ram_rdata) : 33'(lpout_reg) - 33'(mean_reg);
        da_abs  = da_reg[32] ? -da_reg : da_reg;
        q35     = signed'({1'b0, div_q[33:0]});
        qs      = da_reg[32] ? -q35 : q35;
        t1      = 35'(lpout_reg) - 35'(nm_reg);
        t2      = 35'(old_reg) - 35'(mean_reg);
        d2      = full ? t1 + t2 : t1;
        d2_abs  = d2[34] ? -d2 : d2;

        spread_upd = neg_reg ? signed'({2'b0, spread_reg}) - signed'({9'b0, mul_p[71:16]})
                             : signed'({2'b0, spread_reg}) + signed'({9'b0, mul_p[71:16]});
        if (spread_upd[64]) begin
            spread_clamped = '0;
        end else if (spread_upd[63:0] > {1'b0, efn_pkg::SPREAD_MAX}) begin
            spread_clamped = efn_pkg::SPREAD_MAX;
        end else begin
            spread_clamped = spread_upd[62:0];
        end

        var48  = (div_q > 64'(efn_pkg::VAR_MAX)) ? efn_pkg::VAR_MAX : div_q[47:0];

        // Narrow span: recenter on the mean, since mean -/+ 3 sigma sums to 2*mean
        narrow = {sd3_reg, 1'b0} < 35'(min_span_reg);
        mean36 = 36'(mean_reg);
        lo36   = narrow ? mean36 - signed'(36'(min_span_reg[30:1]))
                        : mean36 - signed'({2'b0, sd3_reg});
        hi36   = narrow ? lo36 + signed'(36'(min_span_reg))
                        : mean36 + signed'({2'b0, sd3_reg});

        num    = 33'(lpout_reg) - 33'(lower_reg);
        span   = 33'(upper_reg) - 33'(lower_reg);
        // Value strictly inside a non-empty span: needs the divider
        norm_div = !span[32] && span != '0 && !num[32] && num != '0 && num < span;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_normalized = m_norm_reg;
    assign m_rejected   = m_rej_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            term_reg        <= T_NT_X;
            nin0_reg        <= '0;
            nin1_reg        <= '0;
            nout0_reg       <= '0;
            nout1_reg       <= '0;
            hpin_reg        <= '0;
            hpout_reg       <= '0;
            lpin_reg        <= '0;
            lpout_reg       <= '0;
            mean_reg        <= '0;
            spread_reg      <= '0;
            lower_reg       <= '0;
            upper_reg       <= 32'sd65536;
            fill_reg        <= '0;
            period_reg      <= '0;
            pos_reg         <= '0;
            input_limit_reg <= efn_pkg::INPUT_LIMIT_RST;
            min_span_reg    <= efn_pkg::MIN_SPAN_RST;
            m_valid_reg     <= 1'b0;
            mul_start_reg   <= 1'b0;
            div_start_reg   <= 1'b0;
            sqrt_start_reg  <= 1'b0;
        end else begin
            // Kick the serial units on the cycle their operands are loaded
            mul_start_reg  <= (state_reg == ST_MUL_GO) || (state_reg == ST_WIN_D2);
            div_start_reg  <= (state_reg == ST_WIN_DELTA) || (state_reg == ST_BND_GO) ||
                              (state_reg == ST_NORM && norm_div);
            sqrt_start_reg <= (state_reg == ST_BND_DIV) && div_done;

            if (cfg_valid) begin
                unique case (efn_pkg::cfg_idx_t'(cfg_index))
                    efn_pkg::CFG_INPUT_LIMIT: input_limit_reg <= cfg_data[30:0];
                    efn_pkg::CFG_MIN_SPAN:    min_span_reg    <= cfg_data[30:0];
                    default: ;
                endcase
            end

            // Drop the result once taken, unless a new one is loaded now
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        x_reg     <= s_sample;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    // Out of range: answer zero and leave all state alone
                    if (x_mag > {2'b00, input_limit_reg}) begin
                        res_reg   <= '0;
                        rej_reg   <= 1'b1;
                        state_reg <= ST_OUT;
                    end else begin
                        rej_reg   <= 1'b0;
                        term_reg  <= T_NT_X;
                        acc_reg   <= '0;
                        state_reg <= ST_MUL_GO;
                    end
                end
                ST_MUL_GO: begin
                    mul_a_reg     <= MW'(op_mag);
                    mul_b_reg     <= term_coef(term_reg);
                    neg_reg       <= op_ext[32] ^ term_neg(term_reg);
                    state_reg     <= ST_MUL_WAIT;
                end
                ST_MUL_WAIT: begin
                    if (mul_done) begin
                        acc_reg <= neg_reg ? acc_reg - prod66 : acc_reg + prod66;
                        if (term_reg == T_NT_OUT1 || term_reg == T_HP_OUT ||
                            term_reg == T_LP_OUT) begin
                            state_reg <= ST_ROUND;
                        end else begin
                            term_reg  <= term_t'(term_reg + 1'b1);
                            state_reg <= ST_MUL_GO;
                        end
                    end
                end
                ST_ROUND: begin
                    acc_reg   <= '0;
                    term_reg  <= term_t'(term_reg + 1'b1);
                    unique case (term_reg)
                        T_NT_OUT1: begin
                            nin1_reg  <= nin0_reg;
                            nin0_reg  <= x_reg;
                            nout1_reg <= nout0_reg;
                            nout0_reg <= rnd_val;
                            state_reg <= ST_MUL_GO;
                        end
                        T_HP_OUT: begin
                            hpin_reg  <= nout0_reg;
                            hpout_reg <= rnd_val;
                            state_reg <= ST_MUL_GO;
                        end
                        default: begin
                            lpin_reg  <= hpout_reg;
                            lpout_reg <= rnd_val;
                            state_reg <= ST_WIN_RD;
                        end
                    endcase
                end
                ST_WIN_RD: begin
                    state_reg <= ST_WIN_DELTA;
                end
                ST_WIN_DELTA: begin
                    da_reg        <= da;
                    old_reg       <= ram_rdata;
                    div_n_reg     <= 64'(da[32] ? 33'(-da) : 33'(da));
                    div_d_reg     <= full ? efn_pkg::DIV_DW'(WINDOW_DEPTH)
                                          : efn_pkg::DIV_DW'(fill_reg) + 1'b1;
                    state_reg     <= ST_WIN_DIV;
                end
                ST_WIN_DIV: begin
                    if (div_done) begin
                        nm_reg    <= sat32(66'(35'(mean_reg) + qs));
                        state_reg <= ST_WIN_D2;
                    end
                end
                ST_WIN_D2: begin
                    mul_a_reg     <= MW'(da_abs[31:0]) | (MW'(da_abs[32]) << 32);
                    mul_b_reg     <= MW'(d2_abs);
                    neg_reg       <= da_reg[32] ^ d2[34];
                    mean_reg      <= nm_reg;
                    state_reg     <= ST_WIN_MUL;
                end
                ST_WIN_MUL: begin
                    if (mul_done) begin
                        spread_reg <= spread_clamped;
                        if (!full) begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        pos_reg <= (pos_reg == POS_W'(WINDOW_DEPTH - 1)) ? '0
                                                                        : pos_reg + 1'b1;
                        if (period_reg == CNT_W'(WINDOW_DEPTH - 1)) begin
                            period_reg <= '0;
                            state_reg  <= ST_BND_GO;
                        end else begin
                            period_reg <= period_reg + 1'b1;
                            state_reg  <= ST_NORM;
                        end
                    end
                end
                ST_BND_GO: begin
                    div_n_reg     <= 64'(spread_reg);
                    div_d_reg     <= efn_pkg::DIV_DW'(fill_reg);
                    state_reg     <= ST_BND_DIV;
                end
                ST_BND_DIV: begin
                    if (div_done) begin
                        sqrt_n_reg     <= {var48, 16'b0};
                        state_reg      <= ST_BND_SQRT;
                    end
                end
                ST_BND_SQRT: begin
                    if (sqrt_done) begin
                        sd3_reg   <= 34'(sqrt_root) + {1'b0, sqrt_root, 1'b0};
                        state_reg <= ST_BND_SET;
                    end
                end
                ST_BND_SET: begin
                    lower_reg <= sat32(66'(lo36));
                    upper_reg <= sat32(66'(hi36));
                    state_reg <= ST_NORM;
                end
                ST_NORM: begin
                    // Empty span: step at the lower bound; else clamp or divide
                    if (span[32] || span == '0) begin
                        res_reg   <= (!num[32] && num != '0) ? efn_pkg::RES_ONE : '0;
                        state_reg <= ST_OUT;
                    end else if (num[32] || num == '0) begin
                        res_reg   <= '0;
                        state_reg <= ST_OUT;
                    end else if (num >= span) begin
                        res_reg   <= efn_pkg::RES_ONE;
                        state_reg <= ST_OUT;
                    end else begin
                        div_n_reg     <= {16'b0, num[31:0], 16'b0};
                        div_d_reg     <= efn_pkg::DIV_DW'(span[31:0]);
                        state_reg     <= ST_NORM_DIV;
                    end
                end
                ST_NORM_DIV: begin
                    if (div_done) begin
                        res_reg   <= div_q[16:0];
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // Hold the result until the output register frees up
                    if (!m_valid_reg || m_ready) begin
                        m_norm_reg  <= res_reg;
                        m_rej_reg   <= rej_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    efn_ram #(.W(32), .DEPTH(WINDOW_DEPTH)) u_window (
        .aclk    (aclk),
        .wr_en   (state_reg == ST_WIN_D2),
        .wr_addr (pos_reg),
        .wr_data (lpout_reg),
        .rd_en   (state_reg == ST_WIN_RD),
        .rd_addr (pos_reg),
        .rd_data (ram_rdata)
    );

    efn_mul #(.W(MW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .done    (mul_done),
        .p       (mul_p)
    );

    efn_div #(.NW(efn_pkg::DIV_NW), .DW(efn_pkg::DIV_DW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .n       (div_n_reg),
        .d       (div_d_reg),
        .done    (div_done),
        .q       (div_q)
    );

    efn_sqrt #(.RW(efn_pkg::SQRT_W)) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start_reg),
        .n       (sqrt_n_reg),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    a_mul_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_MUL_WAIT || state_reg == ST_WIN_MUL))
        else $error("multiplier finished outside a multiply wait");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_WIN_DIV || state_reg == ST_BND_DIV ||
                      state_reg == ST_NORM_DIV))
        else $error("divider finished outside a divide wait");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("window fill count overran depth");

    a_accept_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_CHECK))
        else $error("accepted request did not reach range check");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && (!m_valid_reg || m_ready)) |=>
            (m_valid_reg && state_reg == ST_IDLE))
        else $error("result not loaded into output register");

endmodule
`default_nettype wire

/* test/eeg_filter_normalize_tb.sv */
// Self-checking testbench for the EEG filter cascade and window normalizer.
`timescale 1ns / 1ps
module eeg_filter_normalize_tb;

    localparam int DEPTH      = efn_pkg::WINDOW_DEPTH;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 800;

    typedef struct packed {
        logic [16:0] normalized;
        logic        rejected;
    } result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [31:0]            s_sample;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [16:0]                   m_normalized;
    logic                          m_rejected;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [efn_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                   cfg_data;

    eeg_filter_normalize dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_normalized(m_normalized), .m_rejected(m_rejected),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predicted block state, mirrors the hardware registers
    logic [30:0]        lim_q, span_min_q;
    logic signed [31:0] nt_x1, nt_x2, nt_y1, nt_y2;
    logic signed [31:0] hp_x1, hp_y1, lp_x1, lp_y1;
    logic signed [31:0] win_mem [DEPTH];
    int unsigned        fill_n, wr_ptr, refresh_n;
    logic signed [31:0] mean_q;
    logic signed [63:0] m2_q;
    logic signed [31:0] lo_bound, hi_bound;

    result_t pending_results[$];
    int      mismatch_count = 0;
    int      idle_cycles = 0;
    bit      rx_stall_mode = 1'b0;

    // Clock: 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic signed [63:0] floor_sh(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] round_q28(logic signed [63:0] acc);
        return sat32(floor_sh(acc + 64'sd134217728, 28));
    endfunction

    // (a*b)/2^16 truncated toward zero, computed on magnitudes
    function automatic logic signed [63:0] mul_q16_trunc(logic signed [63:0] a,
                                                        logic signed [63:0] b);
        logic        neg;
        logic [63:0] ua, ub, r;
        neg = (a < 0) != (b < 0);
        ua  = a < 0 ? -a : a;
        ub  = b < 0 ? -b : b;
        r   = (ua >> 16) * ub + (((ua & 64'hFFFF) * ub) >> 16);
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [63:0] clamp_m2(logic signed [63:0] v);
        if (v < 0) return 64'sd0;
        if (v > 64'sh4000000000000000) return 64'sh4000000000000000;
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic model_reset();
        lim_q = efn_pkg::INPUT_LIMIT_RST;
        span_min_q = efn_pkg::MIN_SPAN_RST;
        {nt_x1, nt_x2, nt_y1, nt_y2} = '0;
        {hp_x1, hp_y1, lp_x1, lp_y1} = '0;
        fill_n = 0; wr_ptr = 0; refresh_n = 0;
        mean_q = 0; m2_q = 0;
        lo_bound = 0; hi_bound = 65536;
    endtask

    task automatic window_push(logic signed [31:0] v);
        logic signed [63:0] delta, old, om, nm;
        if (fill_n < DEPTH) begin
            delta  = 64'(v) - 64'(mean_q);
            nm     = sat32(64'(mean_q) + delta / $signed(64'(fill_n + 1)));
            mean_q = nm[31:0];
            m2_q   = clamp_m2(m2_q + mul_q16_trunc(delta, 64'(v) - nm));
            fill_n++;
        end else begin
            old    = 64'(win_mem[wr_ptr]);
            delta  = 64'(v) - old;
            om     = 64'(mean_q);
            nm     = sat32(om + delta / $signed(64'(DEPTH)));
            mean_q = nm[31:0];
            m2_q   = clamp_m2(m2_q + mul_q16_trunc(delta, (64'(v) - nm) + (old - om)));
        end
        win_mem[wr_ptr] = v;
        wr_ptr = (wr_ptr + 1) % DEPTH;
    endtask

    task automatic refresh_bounds();
        logic [63:0]        var_q, sd;
        logic signed [63:0] lo, hi, c;
        if (fill_n == 0) return;
        var_q = $unsigned(m2_q) / 64'(fill_n);
        if (var_q > 64'(efn_pkg::VAR_MAX)) var_q = 64'(efn_pkg::VAR_MAX);
        sd = int_sqrt(var_q << 16);
        lo = 64'(mean_q) - 3 * $signed(sd);
        hi = 64'(mean_q) + 3 * $signed(sd);
        if (hi - lo < $signed(64'(span_min_q))) begin
            c  = floor_sh(hi + lo, 1);
            lo = c - $signed(64'(span_min_q >> 1));
            hi = lo + $signed(64'(span_min_q));
        end
        lo_bound = sat32(lo);
        hi_bound = sat32(hi);
    endtask

    // Work out the result of one sample and advance the predicted state
    task automatic predict_normalized(logic signed [31:0] smp, output result_t r);
        logic signed [63:0] x, mag, acc, num, span;
        logic signed [31:0] n, h, l;
        x   = 64'(smp);
        mag = x < 0 ? -x : x;
        r   = '0;
        if (mag > $signed(64'(lim_q))) begin
            r.rejected = 1'b1;
            return;
        end
        acc = $signed(64'(efn_pkg::NT_B0)) * x - $signed(64'(efn_pkg::NT_B1)) * 64'(nt_x1)
            + $signed(64'(efn_pkg::NT_B0)) * 64'(nt_x2)
            + $signed(64'(efn_pkg::NT_B1)) * 64'(nt_y1)
            - $signed(64'(efn_pkg::NT_A2)) * 64'(nt_y2);
        n = round_q28(acc);
        nt_x2 = nt_x1; nt_x1 = smp; nt_y2 = nt_y1; nt_y1 = n;
        acc = $signed(64'(efn_pkg::HP_B)) * 64'(n) - $signed(64'(efn_pkg::HP_B)) * 64'(hp_x1)
            + $signed(64'(efn_pkg::HP_A)) * 64'(hp_y1);
        h = round_q28(acc);
        hp_x1 = n; hp_y1 = h;
        acc = $signed(64'(efn_pkg::LP_B)) * 64'(h) + $signed(64'(efn_pkg::LP_B)) * 64'(lp_x1)
            + $signed(64'(efn_pkg::LP_A)) * 64'(lp_y1);
        l = round_q28(acc);
        lp_x1 = h; lp_y1 = l;
        window_push(l);
        refresh_n++;
        if (refresh_n >= DEPTH) begin
            refresh_bounds();
            refresh_n = 0;
        end
        num  = 64'(l) - 64'(lo_bound);
        span = 64'(hi_bound) - 64'(lo_bound);
        if (span <= 0)        r.normalized = num > 0 ? efn_pkg::RES_ONE : 17'd0;
        else if (num <= 0)    r.normalized = 17'd0;
        else if (num >= span) r.normalized = efn_pkg::RES_ONE;
        else                  r.normalized = 17'((num <<< 16) / span);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Send one sample request; predict at the moment it is taken
    task automatic send_sample(logic signed [31:0] smp);
        result_t r;
        s_valid  <= 1'b1;
        s_sample <= smp;
        do @(posedge aclk); while (!s_ready);
        predict_normalized(smp, r);
        pending_results.push_back(r);
        @(negedge aclk);
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Bursty sender: hold off a random gap now and then
    task automatic send_paced(logic signed [31:0] smp);
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(negedge aclk);
        send_sample(smp);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic write_reg(efn_pkg::cfg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == efn_pkg::CFG_INPUT_LIMIT) lim_q = val[30:0];
        else                                 span_min_q = val[30:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic signed [31:0] eeg_like();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) return $signed($urandom_range(0, 2 * 65536 * 200)) - 65536 * 200;
        if (sel < 9) return $signed($urandom());
        return $signed($urandom_range(0, 65536 * 2000)) - 65536 * 1000;
    endfunction

    task automatic test_field_extremes();
        send_sample(32'sh80000000);
        send_sample(32'sh7FFFFFFF);
        send_sample(32'sd65536000);
        send_sample(-32'sd65536000);
        send_sample(32'sd65536001);
        send_sample(-32'sd65536001);
        send_sample(32'sd0);
        send_sample(32'sh55555555);
        send_sample(32'shAAAAAAAA);
        send_sample(32'sd655360);
        send_sample(-32'sd655360);
        wait_drained();
    endtask

    task automatic test_limit_extremes();
        write_reg(efn_pkg::CFG_INPUT_LIMIT, 32'h0);
        send_sample(32'sd0);
        send_sample(32'sd1);
        send_sample(-32'sd1);
        wait_drained();
        write_reg(efn_pkg::CFG_INPUT_LIMIT, 32'hFFFFFFFF);
        send_sample(32'sh7FFFFFFF);
        send_sample(32'sh80000001);
        send_sample(32'sh80000000);
        wait_drained();
        write_reg(efn_pkg::CFG_INPUT_LIMIT, 32'(efn_pkg::INPUT_LIMIT_RST));
    endtask

    // Feed the window under a given minimum span; wild runs open the limit
    task automatic test_window_phase(logic [31:0] span_val, int count, bit wild);
        write_reg(efn_pkg::CFG_MIN_SPAN, span_val);
        if (wild) write_reg(efn_pkg::CFG_INPUT_LIMIT, 32'h7FFFFFFF);
        repeat (count) send_paced(wild ? $signed($urandom()) : eeg_like());
        wait_drained();
        if (wild) write_reg(efn_pkg::CFG_INPUT_LIMIT, 32'(efn_pkg::INPUT_LIMIT_RST));
    endtask

    // Compare each result against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 32'(m_normalized), 0);
            end else begin
                if (m_normalized !== pending_results[0].normalized)
                    report_mismatch("normalized", 32'(m_normalized),
                                    32'(pending_results[0].normalized));
                if (m_rejected !== pending_results[0].rejected)
                    report_mismatch("rejected", 32'(m_rejected),
                                    32'(pending_results[0].rejected));
                void'(pending_results.pop_front());
            end
        end
    end

    // Receiver stalls: alternate free-running and choppy stretches
    always @(negedge aclk) begin
        if ($urandom_range(0, 199) == 0) rx_stall_mode <= ~rx_stall_mode;
        m_ready <= rx_stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
    end

    // Watchdog: once idle_cycles reaches IDLE_LIMIT with no request, result or write taken, the run ends
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("eeg_filter_normalize: mismatch");
            $finish;
        end
    end

    initial begin
        s_valid = 0; s_sample = 0;
        cfg_valid = 0; cfg_index = efn_pkg::CFG_INPUT_LIMIT; cfg_data = 0;
        aresetn = 0;
        model_reset();
        repeat (11) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        test_field_extremes();
        test_limit_extremes();
        test_window_phase(32'd0, 120, 1'b0);
        test_window_phase(32'h7FFFFFFF, 60, 1'b0);
        test_window_phase(32'd6554, 140, 1'b1);
        test_window_phase(32'hFFFFFFFF, 70, 1'b0);

        wait_drained();
        if (mismatch_count == 0)
            $display("eeg_filter_normalize: match");
        else
            $display("eeg_filter_normalize: mismatch");
        $finish;
    end
endmodule

/* filelist.f */
hdl/efn_pkg.sv
hdl/efn_ram.sv
hdl/efn_mul.sv
hdl/efn_div.sv
hdl/efn_sqrt.sv
hdl/eeg_filter_normalize.sv
test/eeg_filter_normalize_tb.sv
